/* hw/rtl/thread_oncpu_interval_aggregator_macros.svh */
// assertion macros shared by the interval aggregator rtl
`ifndef THREAD_ONCPU_INTERVAL_AGGREGATOR_MACROS_SVH
`define THREAD_ONCPU_INTERVAL_AGGREGATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define TOIA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TOIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/toia_pkg.sv */
// package for the thread on-cpu interval aggregator: constants and types
`default_nettype none

package toia_pkg;

  localparam int          THREADS_DEF        = 256;
  localparam logic [31:0] DEFAULT_WINDOW_DEF = 32'd1000000;

  // thread fields are 8 bits wide, so at most this many slots are addressed
  localparam int SLOT_SPAN = 256;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_AGGR_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TRACE_ONLY  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT2
  } state_t;

  typedef struct packed {
    logic [63:0] start_ns;
    logic [63:0] end_ns;
    logic [63:0] busy_ns;
    logic [31:0] count;
  } stash_t;

endpackage

`default_nettype wire

/* hw/rtl/toia_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none

module toia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/thread_oncpu_interval_aggregator.sv */
// top level of the thread on-cpu interval aggregator
`default_nettype none

// usage
// - a context switch word is taken at a rising edge with start high and busy low
// - busy stays high after a word is taken, through exec and, when it causes two records, through emit2
// - per word: the start and stash rams (one read port each) are read at the accept edge,
//   then exec evaluates and writes back; a word that flushes a stash and emits
//   a fresh interval also passes through emit2 for the second record
// - records leave through an output register, each shown for exactly one cycle
//   with result_valid high; the first record is loaded into the output register from exec
// - last marks the final record caused by a word; a word may cause none
// - the receiver cannot stall; records are never held back or dropped
// - the config channel (cfg_valid/cfg_ready) is always ready; write it only
//   while idle; index 0 is the window, index 1 the filter enable
// - reset (rst, synchronous) clears the config registers, all valid bits,
//   the sequencer and result_valid; no clearing pass over the rams is needed
//   because every entry sits behind a flip-flop valid bit
module thread_oncpu_interval_aggregator
  import toia_pkg::*;
#(
  parameter int          THREADS        = THREADS_DEF,
  parameter logic [31:0] DEFAULT_WINDOW = DEFAULT_WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // command channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [7:0]            off_thread,
  input  wire logic [7:0]            on_thread,
  input  wire logic                  on_traced,
  input  wire logic [63:0]           now_ns,
  // result channel
  output logic                       result_valid,
  output logic [7:0]                 thread,
  output logic [63:0]                start_ns,
  output logic [63:0]                end_ns,
  output logic [63:0]                busy_ns,
  output logic [31:0]                interval_count,
  output logic                       last,
  // config write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  `include "thread_oncpu_interval_aggregator_macros.svh"

  // only slots reachable by an 8-bit thread index get storage
  localparam int DEPTH   = (THREADS < SLOT_SPAN) ? THREADS : SLOT_SPAN;
  localparam int SLOT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STASH_W = $bits(stash_t);

  // thread index to slot, folded modulo the table size
  logic [SLOT_W-1:0] slot_lut [SLOT_SPAN];
  for (genvar g = 0; g < SLOT_SPAN; g++) begin : g_slot
    assign slot_lut[g] = SLOT_W'(g % DEPTH);
  end

  // config registers
  logic [31:0] aggr_window;
  logic        trace_only;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      aggr_window <= '0;
      trace_only  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_AGGR_WINDOW) begin
        aggr_window <= cfg_data[31:0];
      end else if (cfg_index == REG_TRACE_ONLY) begin
        trace_only <= cfg_data[0];
      end
    end
  end

  // sequencer
  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // captured command word
  logic [7:0]        off_raw;
  logic [SLOT_W-1:0] off_slot;
  logic [SLOT_W-1:0] on_slot;
  logic              traced;
  logic [63:0]       now;

  always_ff @(posedge clk) begin
    if (accept) begin
      off_raw  <= off_thread;
      off_slot <= slot_lut[off_thread];
      on_slot  <= slot_lut[on_thread];
      traced   <= on_traced;
      now      <= now_ns;
    end
  end

  // per-thread valid bits in flip-flops
  logic [DEPTH-1:0] run_valid;
  logic [DEPTH-1:0] stash_valid;

  // start-time ram and stash ram, both read at accept, written in exec
  logic [63:0]      run_rdata;
  logic             run_we;
  logic [STASH_W-1:0] stash_rdata_bits;
  stash_t           stash_rd;
  stash_t           stash_wd;
  logic             stash_we;

  toia_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (on_slot),
    .wdata (now),
    .re    (accept),
    .raddr (slot_lut[off_thread]),
    .rdata (run_rdata)
  );

  toia_ram #(
    .WIDTH (STASH_W),
    .DEPTH (DEPTH)
  ) u_stash_ram (
    .clk   (clk),
    .we    (stash_we),
    .waddr (off_slot),
    .wdata (stash_wd),
    .re    (accept),
    .raddr (slot_lut[off_thread]),
    .rdata (stash_rdata_bits)
  );

  assign stash_rd = stash_t'(stash_rdata_bits);

  // evaluation of the outgoing thread
  logic [31:0] win;
  logic        rv;
  logic        sv;
  logic        run_ge;
  logic [63:0] run_d;
  logic        new_reached;
  logic        stash_ge;
  logic [63:0] stash_d;
  logic        stash_reached;
  logic [63:0] merged_busy;
  logic [31:0] merged_count;

  assign win           = (aggr_window == '0) ? DEFAULT_WINDOW : aggr_window;
  assign rv            = run_valid[off_slot];
  assign sv            = stash_valid[off_slot];
  assign run_ge        = (now >= run_rdata);
  assign run_d         = now - run_rdata;
  assign new_reached   = run_ge && (run_d >= {32'd0, win});
  assign stash_ge      = (now >= stash_rd.start_ns);
  assign stash_d       = now - stash_rd.start_ns;
  assign stash_reached = stash_ge && (stash_d >= {32'd0, win});
  assign merged_busy   = stash_rd.busy_ns + now - run_rdata;
  assign merged_count  = (stash_rd.count == '1) ? stash_rd.count : stash_rd.count + 32'd1;

  // decisions taken in the exec cycle
  logic   rec0_en;
  logic   rec0_is_stash;
  logic   rec1_en;
  logic   stash_set;
  logic   stash_clr;
  logic   run_set;
  stash_t fresh;

  assign fresh = '{start_ns: run_rdata, end_ns: now, busy_ns: run_d, count: 32'd1};

  always_comb begin
    state_next    = state;
    rec0_en       = 1'b0;
    rec0_is_stash = 1'b0;
    rec1_en       = 1'b0;
    stash_set     = 1'b0;
    stash_clr     = 1'b0;
    stash_we      = 1'b0;
    stash_wd      = fresh;
    run_set       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        run_set = !trace_only || traced;
        if (rv && run_ge) begin
          priority if (!sv) begin
            if (new_reached) begin
              rec0_en = 1'b1;
            end else begin
              stash_we  = 1'b1;
              stash_set = 1'b1;
            end
          end else if (stash_reached) begin
            // flush the old stash, then emit or restash the new interval
            rec0_en       = 1'b1;
            rec0_is_stash = 1'b1;
            if (new_reached) begin
              rec1_en   = 1'b1;
              stash_clr = 1'b1;
            end else begin
              stash_we  = 1'b1;
              stash_set = 1'b1;
            end
          end else begin
            stash_we = 1'b1;
            stash_wd = '{start_ns: stash_rd.start_ns, end_ns: now,
                         busy_ns: merged_busy, count: merged_count};
          end
        end
        state_next = rec1_en ? ST_EMIT2 : ST_IDLE;
      end
      ST_EMIT2: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign run_we = run_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // valid bits: outgoing start cleared first, incoming start set after;
  // when the same slot goes out and comes back in, only the set is done
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid   <= '0;
      stash_valid <= '0;
    end else if (state == ST_EXEC) begin
      if (rv && !(run_set && (on_slot == off_slot))) begin
        run_valid[off_slot] <= 1'b0;
      end
      if (run_set) begin
        run_valid[on_slot] <= 1'b1;
      end
      if (stash_set) begin
        stash_valid[off_slot] <= 1'b1;
      end else if (stash_clr) begin
        stash_valid[off_slot] <= 1'b0;
      end
    end
  end

  // held second record (always a fresh interval)
  stash_t pend;

  always_ff @(posedge clk) begin
    if (state == ST_EXEC && rec1_en) begin
      pend <= fresh;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_EXEC && rec0_en) || (state == ST_EMIT2);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC && rec0_en) begin
      thread <= off_raw;
      last   <= !rec1_en;
      if (rec0_is_stash) begin
        start_ns       <= stash_rd.start_ns;
        end_ns         <= stash_rd.end_ns;
        busy_ns        <= stash_rd.busy_ns;
        interval_count <= stash_rd.count;
      end else begin
        start_ns       <= fresh.start_ns;
        end_ns         <= fresh.end_ns;
        busy_ns        <= fresh.busy_ns;
        interval_count <= fresh.count;
      end
    end else if (state == ST_EMIT2) begin
      thread         <= off_raw;
      last           <= 1'b1;
      start_ns       <= pend.start_ns;
      end_ns         <= pend.end_ns;
      busy_ns        <= pend.busy_ns;
      interval_count <= pend.count;
    end
  end

  // checks
  `TOIA_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == ST_EXEC, "no exec after accept")
  `TOIA_ASSERT_NEXT(a_exec_once, clk, rst, state == ST_EXEC, state != ST_EXEC, "exec too long")
  `TOIA_ASSERT_NEXT(a_emit2_last, clk, rst, state == ST_EMIT2, result_valid && last, "pair lost")
  `TOIA_ASSERT_NEXT(a_pair_close, clk, rst, result_valid && !last, result_valid && last, "open")

endmodule

`default_nettype wire
